[rtl/core/phong_point_light_shader_unit_assert.svh]
// Assertion macros shared by the shader RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef PHONG_POINT_LIGHT_SHADER_UNIT_ASSERT_SVH
`define PHONG_POINT_LIGHT_SHADER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHONG_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition must never be true outside reset.
`define PHONG_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[rtl/core/phong_pkg.sv]
// Shared types and constants of the point light shader.
// Used by phong_iter_unit and phong_point_light_shader_unit; no dependencies.
package phong_pkg;

   localparam logic [2:0] REG_CAMERA_X = 3'd0;
   localparam logic [2:0] REG_CAMERA_Y = 3'd1;
   localparam logic [2:0] REG_CAMERA_Z = 3'd2;
   localparam logic [2:0] REG_LIGHT_X  = 3'd3;
   localparam logic [2:0] REG_LIGHT_Y  = 3'd4;
   localparam logic [2:0] REG_LIGHT_Z  = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 368;
   localparam int RSP_DATA_W  = 24;

   localparam logic [15:0] ONE_Q15   = 16'd32768;
   localparam logic [31:0] UNIT_Q14  = 32'd16384;
   localparam logic [7:0]  SAT_MAX   = 8'd255;
   localparam logic signed [31:0] SPEC_MIN = 32'sd2;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD_V, S_LOAD_L, S_PICK, S_SHIFT, S_SQ, S_SQRT_GO, S_SQRT_WAIT,
      S_DIV_GO, S_DIV_WAIT, S_RET, S_DLN, S_RR, S_DRV, S_BASE, S_POW, S_COL, S_OUT
   } state_type;

   typedef enum logic [1:0] {VEC_V, VEC_L, VEC_R} vec_sel_type;

   typedef enum logic {OP_SQRT, OP_DIV} iter_op_type;

   typedef struct packed {
      logic        start;
      iter_op_type op;
   } iter_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

endpackage

[rtl/core/phong_iter_unit.sv]
// Shared iterative unit: floor square root of a 64-bit value, one bit pair a cycle,
// and the Q1.14 quotient (a * 2^14) / len, one quotient bit a cycle. Uses phong_pkg.
module phong_iter_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  phong_pkg::iter_ctl_type ctl,
   input  logic [63:0]             radicand,
   input  logic [29:0]             dividend,
   input  logic [31:0]             divisor,
   output phong_pkg::iter_sts_type sts,
   output logic [31:0]             result
);
   import phong_pkg::*;

   localparam logic [4:0] SQRT_LAST = 5'd31;
   localparam logic [4:0] DIV_LAST  = 5'd14;

   logic        busy_ff, busy_in, done_ff, done_in;
   iter_op_type op_ff, op_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [14:0] q_ff, q_in;
   logic        lsb_ff, lsb_in;
   logic [31:0] den_ff, den_in;
   logic [63:0] trial;
   logic [32:0] rem2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      q_in    = q_ff;
      lsb_in  = lsb_ff;
      den_in  = den_ff;
      trial   = r_ff + bit_ff;
      rem2    = {x_ff[31:0], lsb_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         if (ctl.op == OP_SQRT) begin
            x_in   = radicand;
            r_in   = '0;
            bit_in = 64'h4000_0000_0000_0000;
            cnt_in = SQRT_LAST;
         end else begin
            x_in   = 64'(dividend[29:1]);
            q_in   = '0;
            lsb_in = dividend[0];
            den_in = divisor;
            cnt_in = DIV_LAST;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            if (x_ff >= trial) begin
               x_in = x_ff - trial;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            lsb_in = 1'b0;
            if (rem2 >= {1'b0, den_ff}) begin
               x_in = 64'(rem2 - {1'b0, den_ff});
               q_in = {q_ff[13:0], 1'b1};
            end else begin
               x_in = 64'(rem2);
               q_in = {q_ff[13:0], 1'b0};
            end
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_SQRT;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      q_ff   <= q_in;
      lsb_ff <= lsb_in;
      den_ff <= den_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (op_ff == OP_SQRT) ? r_ff[31:0] : 32'(q_ff);

endmodule

[rtl/core/phong_point_light_shader_unit.sv]
// Phong shading of one surface hit under one point light, top level.
// Depends on phong_pkg, phong_iter_unit and phong_point_light_shader_unit_assert.svh.
//
// A request on req_ carries a hit point, its normal and the material; one shaded
// RGB result leaves on rsp_. Camera and light positions are written through the
// csr_ port; the user must write them only while the block is idle, which the
// block itself does not enforce. The block takes one request at a time and
// holds req_tready low until the result is in the output register.
// The time taken grows with the number of normalizing shifts and with the
// shininess; a zero direction skips its normalization.
// The time goes to the three vector normalizations, each of which shifts
// one bit a cycle until the largest magnitude is in range, then runs a
// square root and three divides on the shared iterative unit; the specular
// power uses the one shared multiplier.
// A new request is accepted while the previous result still waits; if the
// receiver stalls, the next result waits in its final state until the output
// register is free. Reset clears the camera and light registers to zero.
`include "phong_point_light_shader_unit_assert.svh"

module phong_point_light_shader_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // hit_x, hit_y, hit_z, surface_normal, base_color, diffuse_color,
   // specular_color, ambient_gain, diffuse_gain, specular_gain, shininess
   input  logic [phong_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // red, green, blue
   output logic [phong_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [phong_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [phong_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import phong_pkg::*;

   state_type   state_ff, state_in;
   vec_sel_type vsel_ff;

   logic signed [31:0] cam_ff [3];
   logic signed [31:0] lgt_ff [3];
   logic signed [31:0] hit_ff [3];
   logic signed [15:0] nrm_ff [3];
   logic [7:0]  ca_ff [3], cd_ff [3], cp_ff [3];
   logic [15:0] ka_ff [3], kd_ff [3], ks_ff [3];
   logic [7:0]  shin_ff;

   logic [47:0] mag_ff [3];
   logic        neg_ff [3];
   logic [1:0]  idx_ff;
   logic [2:0]  step_ff;
   logic [31:0] len_ff;
   logic signed [63:0] acc_ff, prod_ff;
   logic signed [15:0] uv_ff [3][3];
   logic signed [31:0] dln_ff, drv_ff;
   logic [16:0] diff_ff;
   logic        spec_on_ff;
   logic [15:0] base_ff, pw_ff;
   logic [7:0]  cnt_ff;
   logic [1:0]  ch_ff;
   logic [47:0] sum_ff;
   logic [7:0]  res_ff [3];
   logic        rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [32:0] dv [3], dl [3];
   logic signed [31:0] mul_a, mul_b;
   logic [1:0]  pick, k, kp;
   logic [47:0] mcur;
   logic signed [63:0] lsh, rr64;
   logic [18:0] base_raw;
   logic [39:0] sat_v;
   logic signed [15:0] qs;
   logic        out_free;

   iter_ctl_type iu_ctl;
   iter_sts_type iu_sts;
   logic [31:0]  iu_result;

   phong_iter_unit u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (iu_ctl),
      .radicand (acc_ff),
      .dividend (mag_ff[k][29:0]),
      .divisor  (len_ff),
      .sts      (iu_sts),
      .result   (iu_result)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv[i] = {cam_ff[i][31], cam_ff[i]} - {hit_ff[i][31], hit_ff[i]};
         dl[i] = {lgt_ff[i][31], lgt_ff[i]} - {hit_ff[i][31], hit_ff[i]};
      end
      k    = (step_ff[1:0] == 2'd3) ? 2'd0 : step_ff[1:0];
      kp   = (step_ff[1:0] == 2'd0) ? 2'd0 : step_ff[1:0] - 2'd1;
      pick = (mag_ff[1] > mag_ff[0]) ? 2'd1 : 2'd0;
      if (mag_ff[2] > ((pick == 2'd1) ? mag_ff[1] : mag_ff[0])) begin
         pick = 2'd2;
      end
      mcur     = mag_ff[idx_ff];
      lsh      = 64'(uv_ff[VEC_L][kp]) <<< 28;
      rr64     = (prod_ff <<< 1) - lsh;
      base_raw = drv_ff[31] ? '0 : drv_ff[31:13];
      sat_v    = sum_ff[47:8] >> 7;
      qs       = 16'(iu_result[14:0]);
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            if (step_ff < 3'd3) begin
               mul_a = 32'({2'b00, mag_ff[k][29:0]});
               mul_b = 32'({2'b00, mag_ff[k][29:0]});
            end
         end
         S_DLN: begin
            if (step_ff < 3'd3) begin
               mul_a = 32'(uv_ff[VEC_L][k]);
               mul_b = 32'(nrm_ff[k]);
            end
         end
         S_RR: begin
            if (step_ff < 3'd3) begin
               mul_a = 32'(nrm_ff[k]);
               mul_b = dln_ff;
            end
         end
         S_DRV: begin
            if (step_ff < 3'd3) begin
               mul_a = 32'(uv_ff[VEC_R][k]);
               mul_b = 32'(uv_ff[VEC_V][k]);
            end
         end
         S_POW: begin
            mul_a = 32'(pw_ff);
            mul_b = 32'(base_ff);
         end
         S_COL: begin
            case (step_ff)
               3'd0: begin
                  mul_a = 32'(ca_ff[ch_ff]);
                  mul_b = 32'(ka_ff[ch_ff]);
               end
               3'd1: begin
                  mul_a = 32'(cd_ff[ch_ff]);
                  mul_b = 32'(kd_ff[ch_ff]);
               end
               3'd2: begin
                  mul_a = prod_ff[31:0];
                  mul_b = 32'(diff_ff);
               end
               3'd3: begin
                  mul_a = 32'(cp_ff[ch_ff]);
                  mul_b = 32'(ks_ff[ch_ff]);
               end
               3'd4: begin
                  mul_a = prod_ff[31:0];
                  mul_b = 32'(pw_ff);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      iu_ctl     = '{start: 1'b0, op: OP_SQRT};
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_LOAD_V;
            end
         end
         S_LOAD_V: state_in = S_PICK;
         S_LOAD_L: state_in = S_PICK;
         S_PICK: begin
            if (mag_ff[0] == '0 && mag_ff[1] == '0 && mag_ff[2] == '0) begin
               state_in = S_RET;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (mcur[47:30] == '0 && mcur[29]) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (step_ff == 3'd3) begin
               state_in = S_SQRT_GO;
            end
         end
         S_SQRT_GO: begin
            iu_ctl   = '{start: 1'b1, op: OP_SQRT};
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (iu_sts.done) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            iu_ctl   = '{start: 1'b1, op: OP_DIV};
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (iu_sts.done) begin
               state_in = (step_ff == 3'd2) ? S_RET : S_DIV_GO;
            end
         end
         S_RET: begin
            case (vsel_ff)
               VEC_V:   state_in = S_LOAD_L;
               VEC_L:   state_in = S_DLN;
               VEC_R:   state_in = S_DRV;
               default: state_in = S_IDLE;
            endcase
         end
         S_DLN: begin
            if (step_ff == 3'd3) begin
               state_in = S_RR;
            end
         end
         S_RR: begin
            if (step_ff == 3'd3) begin
               state_in = S_PICK;
            end
         end
         S_DRV: begin
            if (step_ff == 3'd3) begin
               state_in = S_BASE;
            end
         end
         S_BASE: state_in = S_POW;
         S_POW: begin
            if (cnt_ff == '0) begin
               state_in = S_COL;
            end
         end
         S_COL: begin
            if (step_ff == 3'd6 && ch_ff == 2'd2) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cam_ff[i] <= '0;
            lgt_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_CAMERA_X: cam_ff[0] <= csr_wdata;
            REG_CAMERA_Y: cam_ff[1] <= csr_wdata;
            REG_CAMERA_Z: cam_ff[2] <= csr_wdata;
            REG_LIGHT_X:  lgt_ff[0] <= csr_wdata;
            REG_LIGHT_Y:  lgt_ff[1] <= csr_wdata;
            REG_LIGHT_Z:  lgt_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  hit_ff[i] <= req_tdata[32*i +: 32];
                  nrm_ff[i] <= req_tdata[96 + 32 - 16*i +: 16];
                  ca_ff[i]  <= req_tdata[144 + 16 - 8*i +: 8];
                  cd_ff[i]  <= req_tdata[168 + 16 - 8*i +: 8];
                  cp_ff[i]  <= req_tdata[192 + 16 - 8*i +: 8];
                  ka_ff[i]  <= req_tdata[216 + 32 - 16*i +: 16];
                  kd_ff[i]  <= req_tdata[264 + 32 - 16*i +: 16];
                  ks_ff[i]  <= req_tdata[312 + 32 - 16*i +: 16];
               end
               shin_ff <= req_tdata[367:360];
            end
         end
         S_LOAD_V: begin
            vsel_ff <= VEC_V;
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= dv[i][32];
               mag_ff[i] <= 48'($unsigned(dv[i][32] ? -dv[i] : dv[i]));
            end
         end
         S_LOAD_L: begin
            vsel_ff <= VEC_L;
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= dl[i][32];
               mag_ff[i] <= 48'($unsigned(dl[i][32] ? -dl[i] : dl[i]));
            end
         end
         S_PICK: begin
            idx_ff <= pick;
            if (mag_ff[0] == '0 && mag_ff[1] == '0 && mag_ff[2] == '0) begin
               for (int i = 0; i < 3; i++) begin
                  uv_ff[vsel_ff][i] <= '0;
               end
            end
         end
         S_SHIFT: begin
            if (mcur[47:30] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end else if (!mcur[29]) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end else begin
               step_ff <= '0;
               acc_ff  <= '0;
            end
         end
         S_SQ: begin
            if (step_ff != 3'd0) begin
               acc_ff <= acc_ff + prod_ff;
            end
            step_ff <= step_ff + 3'd1;
         end
         S_SQRT_WAIT: begin
            if (iu_sts.done) begin
               len_ff  <= iu_result;
               step_ff <= '0;
            end
         end
         S_DIV_WAIT: begin
            if (iu_sts.done) begin
               uv_ff[vsel_ff][k] <= neg_ff[k] ? -qs : qs;
               step_ff <= step_ff + 3'd1;
            end
         end
         S_RET: begin
            step_ff <= '0;
            acc_ff  <= '0;
         end
         S_DLN: begin
            if (step_ff == 3'd3) begin
               dln_ff  <= 32'(acc_ff + prod_ff);
               step_ff <= '0;
            end else begin
               if (step_ff != 3'd0) begin
                  acc_ff <= acc_ff + prod_ff;
               end
               step_ff <= step_ff + 3'd1;
            end
         end
         S_RR: begin
            if (step_ff != 3'd0) begin
               neg_ff[kp] <= rr64[63];
               mag_ff[kp] <= 48'($unsigned(rr64[63] ? -rr64 : rr64));
            end
            vsel_ff <= VEC_R;
            step_ff <= step_ff + 3'd1;
         end
         S_DRV: begin
            if (step_ff == 3'd3) begin
               drv_ff <= 32'(acc_ff + prod_ff);
            end else begin
               if (step_ff != 3'd0) begin
                  acc_ff <= acc_ff + prod_ff;
               end
               step_ff <= step_ff + 3'd1;
            end
         end
         S_BASE: begin
            diff_ff    <= dln_ff[31] ? '0 : dln_ff[30:14];
            spec_on_ff <= dln_ff > SPEC_MIN;
            base_ff    <= (base_raw > 19'(ONE_Q15)) ? ONE_Q15 : base_raw[15:0];
            pw_ff      <= ONE_Q15;
            cnt_ff     <= shin_ff;
            step_ff    <= '0;
         end
         S_POW: begin
            if (cnt_ff == '0) begin
               step_ff <= '0;
               ch_ff   <= '0;
               sum_ff  <= '0;
            end else if (step_ff == 3'd0) begin
               step_ff <= 3'd1;
            end else begin
               pw_ff   <= prod_ff[30:15];
               cnt_ff  <= cnt_ff - 8'd1;
               step_ff <= '0;
            end
         end
         S_COL: begin
            case (step_ff)
               3'd1: sum_ff <= prod_ff[47:0];
               3'd3: sum_ff <= sum_ff + prod_ff[61:14];
               3'd5: begin
                  if (spec_on_ff) begin
                     sum_ff <= sum_ff + prod_ff[62:15];
                  end
               end
               3'd6: begin
                  res_ff[ch_ff] <= (sat_v > 40'(SAT_MAX)) ? SAT_MAX : sat_v[7:0];
                  ch_ff <= ch_ff + 2'd1;
               end
               default: ;
            endcase
            step_ff <= (step_ff == 3'd6) ? 3'd0 : step_ff + 3'd1;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PHONG_ASSERT_NEVER(a_iter_start_busy, iu_ctl.start && iu_sts.busy, "iter unit restarted while busy")
   `PHONG_ASSERT_IMP(a_shift_nonzero, state_ff == S_SHIFT, mcur != '0, "normalizing a zero vector")
   `PHONG_ASSERT_IMP(a_div_bound, state_ff == S_DIV_WAIT && iu_sts.done, iu_result <= UNIT_Q14, "unit component above one")
   `PHONG_ASSERT_IMP(a_pow_base, state_ff == S_POW, base_ff <= ONE_Q15 && pw_ff <= ONE_Q15, "specular power out of range")

endmodule

[tb/phong_point_light_shader_unit_test.sv]
// Self-checking bench for phong_point_light_shader_unit: random hit requests, camera and light
// settings, compared against an in-bench fixed-point Phong shading predictor.
// Depends on phong_pkg and the shader RTL.
module phong_point_light_shader_unit_test;
   import phong_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_CAMERA_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   phong_point_light_shader_unit uut (.*);

   initial forever #10 clock = ~clock;
   initial begin
      #400000000;
      $display("TB_ERROR");
      $finish;
   end

   typedef struct packed {
      logic [7:0]  shine;
      logic [47:0] ks, kd, ka;
      logic [23:0] cs, cd, ca;
      logic [47:0] normal;
      logic [31:0] hz, hy, hx;
   } hit_type;

   logic signed [31:0] eye_pos [3];
   logic signed [31:0] lamp_pos [3];
   hit_type pending_hits [$];
   logic [23:0] expected_colors [$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int errors = 0;

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin x -= r + b; r = (r >> 1) + b; end
         else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   task automatic normalize(input longint d [3], output longint u [3]);
      logic [63:0] a [3];
      logic [63:0] m, sum, len;
      int s;
      bit down;
      m = 0; sum = 0; s = 0; down = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = d[i] < 0 ? -d[i] : d[i];
         if (a[i] > m) m = a[i];
      end
      if (m == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
         return;
      end
      while (m >= (64'd1 << 30)) begin m >>= 1; s++; down = 1; end
      while (m < (64'd1 << 29)) begin m <<= 1; s++; end
      for (int i = 0; i < 3; i++) begin
         a[i] = down ? a[i] >> s : a[i] << s;
         sum += a[i] * a[i];
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'((a[i] << 14) / len);
         if (d[i] < 0) u[i] = -u[i];
      end
   endtask

   task automatic shade(input hit_type h, output logic [23:0] rgb);
      longint hp [3], vd [3], ld [3], v [3], l [3], n [3], rr [3], r [3];
      longint dln, drv;
      logic [63:0] diff, base, pw, sum, ca, cd, cp, ka, kd, ks;
      hp[0] = longint'($signed(h.hx));
      hp[1] = longint'($signed(h.hy));
      hp[2] = longint'($signed(h.hz));
      n[0] = longint'($signed(h.normal[47:32]));
      n[1] = longint'($signed(h.normal[31:16]));
      n[2] = longint'($signed(h.normal[15:0]));
      for (int i = 0; i < 3; i++) begin
         vd[i] = longint'(eye_pos[i]) - hp[i];
         ld[i] = longint'(lamp_pos[i]) - hp[i];
      end
      normalize(vd, v);
      normalize(ld, l);
      dln = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
      for (int i = 0; i < 3; i++) rr[i] = 2 * n[i] * dln - l[i] * (64'sd1 <<< 28);
      normalize(rr, r);
      drv = r[0] * v[0] + r[1] * v[1] + r[2] * v[2];
      diff = dln > 0 ? dln >> 14 : 0;
      base = drv > 0 ? drv >> 13 : 0;
      if (base > 32768) base = 32768;
      pw = 32768;
      for (int k = 0; k < h.shine; k++) pw = (pw * base) >> 15;
      for (int c = 0; c < 3; c++) begin
         ca = (h.ca >> (16 - 8 * c)) & 8'hFF;
         cd = (h.cd >> (16 - 8 * c)) & 8'hFF;
         cp = (h.cs >> (16 - 8 * c)) & 8'hFF;
         ka = (h.ka >> (32 - 16 * c)) & 16'hFFFF;
         kd = (h.kd >> (32 - 16 * c)) & 16'hFFFF;
         ks = (h.ks >> (32 - 16 * c)) & 16'hFFFF;
         sum = ca * ka + ((cd * kd * diff) >> 14);
         if (dln > SPEC_MIN) sum += (cp * ks * pw) >> 15;
         sum >>= 15;
         rgb[16 - 8 * c +: 8] = sum > 255 ? SAT_MAX : sum[7:0];
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            logic [23:0] e;
            shade(hit_type'(req_tdata), e);
            expected_colors.push_back(e);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_hits.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1;
               req_tdata <= pending_hits.pop_front();
            end else
               req_tvalid <= 0;
         end
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_colors.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_tdata);
            errors++;
         end else begin
            logic [23:0] e;
            e = expected_colors.pop_front();
            if (e[23:16] !== rsp_tdata[7:0]) begin
               $error("red expected %0d got %0d", e[23:16], rsp_tdata[7:0]);
               errors++;
            end
            if (e[15:8] !== rsp_tdata[15:8]) begin
               $error("green expected %0d got %0d", e[15:8], rsp_tdata[15:8]);
               errors++;
            end
            if (e[7:0] !== rsp_tdata[23:16]) begin
               $error("blue expected %0d got %0d", e[7:0], rsp_tdata[23:16]);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 2048) - 1024;
         3: return ($urandom_range(0, 200) - 100) <<< 16;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_normal_part();
      case ($urandom_range(4))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'($urandom_range(0, 32768) - 16384);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic hit_type random_hit();
      hit_type h;
      h.hx = pick_coord(); h.hy = pick_coord(); h.hz = pick_coord();
      h.normal = {pick_normal_part(), pick_normal_part(), pick_normal_part()};
      h.ca = 24'($urandom()); h.cd = 24'($urandom()); h.cs = 24'($urandom());
      h.ka = 48'({$urandom(), $urandom()}); h.kd = 48'({$urandom(), $urandom()});
      h.ks = 48'({$urandom(), $urandom()});
      if ($urandom_range(3) == 0) begin
         h.ka = {3{16'($urandom_range(0, 8192))}} & 48'h7FFF_7FFF_7FFF;
         h.kd = {3{16'h4000}};
      end
      h.shine = $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 16));
      return h;
   endfunction

   task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx < 3) eye_pos[idx] = val; else lamp_pos[idx - 3] = val;
   endtask

   task automatic drain();
      while (pending_hits.size() > 0 || req_tvalid || expected_colors.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_scene(input logic [31:0] c [6]);
      drain();
      set_reg(REG_CAMERA_X, c[0]); set_reg(REG_CAMERA_Y, c[1]);
      set_reg(REG_CAMERA_Z, c[2]); set_reg(REG_LIGHT_X, c[3]);
      set_reg(REG_LIGHT_Y, c[4]); set_reg(REG_LIGHT_Z, c[5]);
   endtask

   initial begin
      hit_type h;
      logic [31:0] sc [6];
      for (int i = 0; i < 3; i++) begin eye_pos[i] = 0; lamp_pos[i] = 0; end
      repeat (10) @(posedge clock);
      reset <= 0;
      // Directed requests: camera and light at the origin, then a simple lit scene.
      h = '0;
      pending_hits.push_back(h);
      sc = '{0, 0, 32'h000A_0000, 32'h0005_0000, 32'h0005_0000, 32'h000A_0000};
      set_scene(sc);
      h.normal = {16'h0, 16'h0, 16'h4000};
      h.ca = 24'hFFFFFF; h.cd = 24'hFFFFFF; h.cs = 24'hFFFFFF;
      h.ka = {3{16'hFFFF}}; h.kd = {3{16'hFFFF}}; h.ks = {3{16'hFFFF}};
      h.shine = 8'hFF;
      pending_hits.push_back(h);
      h.shine = 0;
      pending_hits.push_back(h);
      h.ka = {3{16'h1000}}; h.kd = {3{16'h4000}}; h.ks = {3{16'h8000}}; h.shine = 8;
      pending_hits.push_back(h);
      h.normal = {16'h0, 16'h0, 16'hC000};
      pending_hits.push_back(h);
      h.normal = {16'h7FFF, 16'h7FFF, 16'h7FFF};
      pending_hits.push_back(h);
      h.normal = {16'h8000, 16'h8000, 16'h8000};
      pending_hits.push_back(h);
      h.normal = {16'h0, 16'h0, 16'h4000};
      h.hx = 32'h0005_0000; h.hy = 32'h0005_0000; h.hz = 32'h000A_0000;
      pending_hits.push_back(h);
      h.hx = 0; h.hy = 0;
      pending_hits.push_back(h);
      h.hx = 32'h8000_0000; h.hy = 32'h7FFF_FFFF; h.hz = 32'h8000_0000;
      pending_hits.push_back(h);
      h = '1;
      pending_hits.push_back(h);
      for (int i = 0; i < 8; i++) pending_hits.push_back(random_hit());
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: sc = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            1: sc = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            default: for (int i = 0; i < 6; i++) sc[i] = pick_coord();
         endcase
         set_scene(sc);
         send_idle_pct = phase < 2 ? 21 : phase < 4 ? 80 : 0;
         recv_idle_pct = phase < 2 ? 80 : phase < 4 ? 21 : 0;
         for (int i = 0; i < 205; i++) pending_hits.push_back(random_hit());
      end
      drain();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/phong_pkg.sv
rtl/core/phong_iter_unit.sv
rtl/core/phong_point_light_shader_unit.sv
tb/phong_point_light_shader_unit_test.sv
